// File: hw/rtl/cdt_pkg.sv
// ----------------------------------------------------------------------------
// Countdown timer controller package
// Shared widths, codes and types of the countdown timer controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cdt_pkg;

	localparam int TIME_BITS  = 16;
	localparam int TOTAL_BITS = 32;
	localparam int STEP_W     = 12;
	localparam int PHASE_W    = 4;
	localparam int HOLD_W     = 8;
	localparam int CMD_W      = 3;
	localparam int STATUS_W   = 2;
	localparam int STATE_W    = 3;
	localparam int MSG_W      = 2;
	localparam int SHOW_W     = 32;
	localparam int REM_W      = 16;
	localparam int PROD_W     = 32;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;
	localparam int REG_IDX_W  = 2;

	localparam logic [STEP_W-1:0]  STEP_RESET     = STEP_W'(60);
	localparam logic [PHASE_W-1:0] CD_PHASE_RESET = PHASE_W'(10);
	localparam logic [PHASE_W-1:0] BEEP_RESET     = PHASE_W'(5);
	localparam logic [HOLD_W-1:0]  HOLD_RESET     = HOLD_W'(30);

	localparam logic [REG_IDX_W-1:0] REG_STEP     = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CD_PHASE = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BEEP     = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_HOLD     = 2'd3;

	localparam logic [CMD_W-1:0] CMD_INC   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DEC   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TICK  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_START = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ABORT = 3'd4;

	localparam logic [STATUS_W-1:0] STS_HANDLED = 2'd0;
	localparam logic [STATUS_W-1:0] STS_IGNORED = 2'd1;
	localparam logic [STATUS_W-1:0] STS_TRANS   = 2'd2;

	localparam logic [MSG_W-1:0] MSG_NONE   = 2'd0;
	localparam logic [MSG_W-1:0] MSG_SET    = 2'd1;
	localparam logic [MSG_W-1:0] MSG_PAUSED = 2'd2;
	localparam logic [MSG_W-1:0] MSG_PROD   = 2'd3;

	typedef enum logic [STATE_W-1:0] {
		MODE_IDLE  = 3'd0,
		MODE_SET   = 3'd1,
		MODE_RUN   = 3'd2,
		MODE_PAUSE = 3'd3,
		MODE_STAT  = 3'd4
	} mode_t;

	typedef struct packed {
		logic [STEP_W-1:0]  step_seconds;
		logic [PHASE_W-1:0] countdown_phase;
		logic [PHASE_W-1:0] beep_phase;
		logic [HOLD_W-1:0]  stat_hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [PHASE_W-1:0] tick_phase;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [STATE_W-1:0]  new_state;
		logic                display_cleared;
		logic                time_shown;
		logic [SHOW_W-1:0]   shown_seconds;
		logic [MSG_W-1:0]    message_code;
		logic [REM_W-1:0]    remaining_seconds;
		logic [PROD_W-1:0]   productive_total;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/cdt_if.sv
// ----------------------------------------------------------------------------
// Countdown timer controller channels
// Valid/ready channels for event beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdt_item_if;
	logic                        valid;
	logic                        ready;
	logic [cdt_pkg::CMD_W-1:0]   command;
	logic [cdt_pkg::PHASE_W-1:0] tick_phase;

	modport source (output valid, command, tick_phase, input ready);
	modport sink   (input valid, command, tick_phase, output ready);
endinterface

interface cdt_result_if;
	logic                         valid;
	logic                         ready;
	logic [cdt_pkg::STATUS_W-1:0] status;
	logic [cdt_pkg::STATE_W-1:0]  new_state;
	logic                         display_cleared;
	logic                         time_shown;
	logic [cdt_pkg::SHOW_W-1:0]   shown_seconds;
	logic [cdt_pkg::MSG_W-1:0]    message_code;
	logic [cdt_pkg::REM_W-1:0]    remaining_seconds;
	logic [cdt_pkg::PROD_W-1:0]   productive_total;

	modport source (output valid, status, new_state, display_cleared, time_shown,
		shown_seconds, message_code, remaining_seconds, productive_total, input ready);
	modport sink   (input valid, status, new_state, display_cleared, time_shown,
		shown_seconds, message_code, remaining_seconds, productive_total, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/countdown_timer_controller_core.sv
// ----------------------------------------------------------------------------
// Countdown timer controller core
// Event register, state machine and result register behind valid/ready.
// ----------------------------------------------------------------------------
// Each event beat is taken into an input register, runs through the state
// machine and lands in a result register, so the core sustains one event
// per clock while the result is not stalled; the result beat is valid once
// its event has passed the input register and then the result register. The
// state counters update as the event leaves the input register, so the
// following event already sees them. A stalled result holds the input
// register, and the input side keeps taking beats while the result register
// is free or being drained. Configuration is by an APB-style port: step at
// 0x0, countdown phase at 0x4, idle beep phase at 0x8, statistics hold at 0xC.
`default_nettype none

module countdown_timer_controller_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [cdt_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [cdt_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [cdt_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready,
	cdt_item_if.sink                            item,
	cdt_result_if.source                        result
);

	cdt_pkg::cfg_t     cfg;
	cdt_pkg::item_t    item_s1;
	logic              valid_s1;
	cdt_pkg::result_t  res_comb;
	cdt_pkg::result_t  result_q;
	logic              out_valid_q;
	logic              advance;

	cdt_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cdt_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_comb)
	);

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.command    <= item.command;
			item_s1.tick_phase <= item.tick_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_comb;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.status            = result_q.status;
	assign result.new_state         = result_q.new_state;
	assign result.display_cleared   = result_q.display_cleared;
	assign result.time_shown        = result_q.time_shown;
	assign result.shown_seconds     = result_q.shown_seconds;
	assign result.message_code      = result_q.message_code;
	assign result.remaining_seconds = result_q.remaining_seconds;
	assign result.productive_total  = result_q.productive_total;

endmodule

`default_nettype wire

// File: hw/rtl/cdt_cfg_regs.sv
// ----------------------------------------------------------------------------
// Countdown timer configuration registers
// APB-style register file holding step, phases and statistics hold time.
// ----------------------------------------------------------------------------
`default_nettype none

module cdt_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [cdt_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [cdt_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [cdt_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                  pready,
	output cdt_pkg::cfg_t                         cfg
);

	cdt_pkg::cfg_t                    cfg_q;
	logic [cdt_pkg::REG_IDX_W-1:0]    reg_idx;
	logic                             wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[cdt_pkg::APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_seconds    <= cdt_pkg::STEP_RESET;
			cfg_q.countdown_phase <= cdt_pkg::CD_PHASE_RESET;
			cfg_q.beep_phase      <= cdt_pkg::BEEP_RESET;
			cfg_q.stat_hold_ticks <= cdt_pkg::HOLD_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				cdt_pkg::REG_STEP:     cfg_q.step_seconds    <= pwdata[cdt_pkg::STEP_W-1:0];
				cdt_pkg::REG_CD_PHASE: cfg_q.countdown_phase <= pwdata[cdt_pkg::PHASE_W-1:0];
				cdt_pkg::REG_BEEP:     cfg_q.beep_phase      <= pwdata[cdt_pkg::PHASE_W-1:0];
				cdt_pkg::REG_HOLD:     cfg_q.stat_hold_ticks <= pwdata[cdt_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			cdt_pkg::REG_STEP:     prdata = cdt_pkg::APB_DATA_W'(cfg_q.step_seconds);
			cdt_pkg::REG_CD_PHASE: prdata = cdt_pkg::APB_DATA_W'(cfg_q.countdown_phase);
			cdt_pkg::REG_BEEP:     prdata = cdt_pkg::APB_DATA_W'(cfg_q.beep_phase);
			cdt_pkg::REG_HOLD:     prdata = cdt_pkg::APB_DATA_W'(cfg_q.stat_hold_ticks);
			default:               prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/cdt_fsm.sv
// ----------------------------------------------------------------------------
// Countdown timer state machine
// Holds mode and counters; works out one event's result and next state.
// ----------------------------------------------------------------------------
`default_nettype none

module cdt_fsm (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  cdt_pkg::item_t         item,
	input  cdt_pkg::cfg_t          cfg,
	output cdt_pkg::result_t       result
);

	localparam int ADD_W = ((cdt_pkg::TIME_BITS > cdt_pkg::STEP_W) ?
		cdt_pkg::TIME_BITS : cdt_pkg::STEP_W) + 1;
	localparam int ACC_W = ((cdt_pkg::TOTAL_BITS > cdt_pkg::TIME_BITS) ?
		cdt_pkg::TOTAL_BITS : cdt_pkg::TIME_BITS) + 1;

	cdt_pkg::mode_t                   mode_q, mode_d;
	logic [cdt_pkg::TIME_BITS-1:0]    remaining_q, remaining_d;
	logic [cdt_pkg::TIME_BITS-1:0]    elapsed_q, elapsed_d;
	logic [cdt_pkg::TOTAL_BITS-1:0]   total_q, total_d;
	logic [cdt_pkg::HOLD_W-1:0]       hold_q, hold_d;

	logic [ADD_W-1:0]                 rem_ext, step_ext, rem_sum;
	logic [cdt_pkg::TIME_BITS-1:0]    rem_add, rem_sub, rem_tick, ela_tick, ela_bank;
	logic                             dec_ok;
	logic [ACC_W-1:0]                 acc_sum;
	logic [cdt_pkg::TOTAL_BITS-1:0]   tot_bank;
	logic [cdt_pkg::HOLD_W-1:0]       hold_inc;
	logic                             cd_tick;

	logic [cdt_pkg::STATUS_W-1:0]     status;
	logic                             clr;
	logic                             shown;
	logic [cdt_pkg::SHOW_W-1:0]       secs;
	logic [cdt_pkg::MSG_W-1:0]        msg;

	always_comb begin
		rem_ext  = ADD_W'(remaining_q);
		step_ext = ADD_W'(cfg.step_seconds);
		rem_sum  = rem_ext + step_ext;
		rem_add  = (rem_sum > ADD_W'({cdt_pkg::TIME_BITS{1'b1}})) ?
			{cdt_pkg::TIME_BITS{1'b1}} : cdt_pkg::TIME_BITS'(rem_sum);
		dec_ok   = rem_ext >= step_ext;
		rem_sub  = cdt_pkg::TIME_BITS'(rem_ext - step_ext);
		rem_tick = (remaining_q == '0) ? '0 : remaining_q - 1'b1;
		ela_tick = (elapsed_q == {cdt_pkg::TIME_BITS{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
		ela_bank = (item.command == cdt_pkg::CMD_TICK) ? ela_tick : elapsed_q;
		acc_sum  = ACC_W'(total_q) + ACC_W'(ela_bank);
		tot_bank = (acc_sum > ACC_W'({cdt_pkg::TOTAL_BITS{1'b1}})) ?
			{cdt_pkg::TOTAL_BITS{1'b1}} : cdt_pkg::TOTAL_BITS'(acc_sum);
		hold_inc = hold_q + 1'b1;
		cd_tick  = item.tick_phase == cfg.countdown_phase;
	end

	always_comb begin
		mode_d      = mode_q;
		remaining_d = remaining_q;
		elapsed_d   = elapsed_q;
		total_d     = total_q;
		hold_d      = hold_q;
		status      = cdt_pkg::STS_IGNORED;
		clr         = 1'b0;
		shown       = 1'b0;
		secs        = '0;
		msg         = cdt_pkg::MSG_NONE;
		case (mode_q)
			cdt_pkg::MODE_IDLE: begin
				case (item.command)
					cdt_pkg::CMD_INC: begin
						remaining_d = rem_add;
						mode_d      = cdt_pkg::MODE_SET;
						status      = cdt_pkg::STS_TRANS;
						clr         = 1'b1;
						shown       = 1'b1;
						secs        = cdt_pkg::SHOW_W'(rem_add);
					end
					cdt_pkg::CMD_START: begin
						mode_d = cdt_pkg::MODE_STAT;
						status = cdt_pkg::STS_TRANS;
						clr    = 1'b1;
						shown  = 1'b1;
						secs   = cdt_pkg::SHOW_W'(total_q);
						msg    = cdt_pkg::MSG_PROD;
					end
					cdt_pkg::CMD_TICK: begin
						status = (item.tick_phase == cfg.beep_phase) ?
							cdt_pkg::STS_HANDLED : cdt_pkg::STS_IGNORED;
					end
					default: ;
				endcase
			end
			cdt_pkg::MODE_SET: begin
				case (item.command)
					cdt_pkg::CMD_INC: begin
						remaining_d = rem_add;
						status      = cdt_pkg::STS_HANDLED;
						shown       = 1'b1;
						secs        = cdt_pkg::SHOW_W'(rem_add);
					end
					cdt_pkg::CMD_DEC: begin
						if (dec_ok) begin
							remaining_d = rem_sub;
							status      = cdt_pkg::STS_HANDLED;
							shown       = 1'b1;
							secs        = cdt_pkg::SHOW_W'(rem_sub);
						end
					end
					cdt_pkg::CMD_ABORT: begin
						mode_d      = cdt_pkg::MODE_IDLE;
						status      = cdt_pkg::STS_TRANS;
						clr         = 1'b1;
						remaining_d = '0;
						elapsed_d   = '0;
						shown       = 1'b1;
						msg         = cdt_pkg::MSG_SET;
					end
					cdt_pkg::CMD_START: begin
						if (dec_ok) begin
							mode_d = cdt_pkg::MODE_RUN;
							status = cdt_pkg::STS_TRANS;
							clr    = 1'b1;
						end
					end
					default: ;
				endcase
			end
			cdt_pkg::MODE_RUN: begin
				case (item.command)
					cdt_pkg::CMD_TICK: begin
						if (cd_tick) begin
							shown = 1'b1;
							if (rem_tick == '0) begin
								mode_d      = cdt_pkg::MODE_IDLE;
								status      = cdt_pkg::STS_TRANS;
								total_d     = tot_bank;
								remaining_d = '0;
								elapsed_d   = '0;
								msg         = cdt_pkg::MSG_SET;
							end else begin
								remaining_d = rem_tick;
								elapsed_d   = ela_tick;
								status      = cdt_pkg::STS_HANDLED;
								secs        = cdt_pkg::SHOW_W'(rem_tick);
							end
						end
					end
					cdt_pkg::CMD_START: begin
						mode_d    = cdt_pkg::MODE_PAUSE;
						status    = cdt_pkg::STS_TRANS;
						total_d   = tot_bank;
						elapsed_d = '0;
						msg       = cdt_pkg::MSG_PAUSED;
					end
					cdt_pkg::CMD_ABORT: begin
						mode_d      = cdt_pkg::MODE_IDLE;
						status      = cdt_pkg::STS_TRANS;
						total_d     = tot_bank;
						remaining_d = '0;
						elapsed_d   = '0;
						shown       = 1'b1;
						msg         = cdt_pkg::MSG_SET;
					end
					default: ;
				endcase
			end
			cdt_pkg::MODE_PAUSE: begin
				case (item.command)
					cdt_pkg::CMD_INC: begin
						remaining_d = rem_add;
						mode_d      = cdt_pkg::MODE_SET;
						status      = cdt_pkg::STS_TRANS;
						clr         = 1'b1;
						shown       = 1'b1;
						secs        = cdt_pkg::SHOW_W'(rem_add);
					end
					cdt_pkg::CMD_DEC: begin
						if (dec_ok) begin
							remaining_d = rem_sub;
							mode_d      = cdt_pkg::MODE_SET;
							status      = cdt_pkg::STS_TRANS;
							clr         = 1'b1;
							shown       = 1'b1;
							secs        = cdt_pkg::SHOW_W'(rem_sub);
						end
					end
					cdt_pkg::CMD_START: begin
						mode_d = cdt_pkg::MODE_RUN;
						status = cdt_pkg::STS_TRANS;
						clr    = 1'b1;
					end
					cdt_pkg::CMD_ABORT: begin
						mode_d      = cdt_pkg::MODE_IDLE;
						status      = cdt_pkg::STS_TRANS;
						clr         = 1'b1;
						remaining_d = '0;
						elapsed_d   = '0;
						shown       = 1'b1;
						msg         = cdt_pkg::MSG_SET;
					end
					default: ;
				endcase
			end
			cdt_pkg::MODE_STAT: begin
				if (item.command == cdt_pkg::CMD_TICK) begin
					if (hold_inc == cfg.stat_hold_ticks) begin
						hold_d      = '0;
						mode_d      = cdt_pkg::MODE_IDLE;
						status      = cdt_pkg::STS_TRANS;
						clr         = 1'b1;
						remaining_d = '0;
						elapsed_d   = '0;
						shown       = 1'b1;
						msg         = cdt_pkg::MSG_SET;
					end else begin
						hold_d = hold_inc;
					end
				end
			end
			default: ;
		endcase

		result.status            = status;
		result.new_state         = mode_d;
		result.display_cleared   = clr;
		result.time_shown        = shown;
		result.shown_seconds     = secs;
		result.message_code      = msg;
		result.remaining_seconds = cdt_pkg::REM_W'(remaining_d);
		result.productive_total  = cdt_pkg::PROD_W'(total_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= cdt_pkg::MODE_IDLE;
			remaining_q <= '0;
			elapsed_q   <= '0;
			total_q     <= '0;
			hold_q      <= '0;
		end else if (fire) begin
			mode_q      <= mode_d;
			remaining_q <= remaining_d;
			elapsed_q   <= elapsed_d;
			total_q     <= total_d;
			hold_q      <= hold_d;
		end
	end

`ifndef SYNTH
	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(mode_q) && $stable(remaining_q) && $stable(total_q))
		else $error("state moved without a beat");

	a_mode_only_on_trans: assert property (@(posedge clk) disable iff (!arst_n)
		fire && status != cdt_pkg::STS_TRANS |=> mode_q == $past(mode_q))
		else $error("mode changed without a transition");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> total_q >= $past(total_q))
		else $error("productive total decreased");

	a_idle_entry_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && status == cdt_pkg::STS_TRANS && mode_d == cdt_pkg::MODE_IDLE
		|=> remaining_q == '0 && elapsed_q == '0)
		else $error("idle entry left time counters set");
`endif

endmodule

`default_nettype wire

// File: tb/sv/cdt_timer_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Countdown timer controller result check
// Watches the event and result channels and the configuration port, runs its
// own model of the five-state timer on every accepted event beat and compares
// each accepted result beat, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------

module cdt_timer_check
	import cdt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	cdt_item_if                   item,
	cdt_result_if                 result,
	output int unsigned           mismatches,
	output int unsigned           outstanding
);

	cfg_t                  cfg;
	mode_t                 run_mode;
	logic [TIME_BITS-1:0]  secs_left;
	logic [TIME_BITS-1:0]  secs_run;
	logic [TOTAL_BITS-1:0] prod_total;
	logic [HOLD_W-1:0]     hold_seen;

	result_t     timer_expect[$];
	result_t     got;
	result_t     want;
	int unsigned mismatch_count = 0;

	assign mismatches = mismatch_count;

	task automatic report(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] seen,
		input logic [31:0] predicted);
		if (seen !== predicted)
			report($sformatf("%s got 0x%0h, expected 0x%0h", name, seen, predicted));
	endtask

	task automatic add_step();
		logic [TIME_BITS:0] sum;
		sum = secs_left + cfg.step_seconds;
		secs_left = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
	endtask

	task automatic step_timer(input item_t ev, output result_t res);
		mode_t                 from_mode;
		logic [STATUS_W-1:0]   sts;
		logic [TOTAL_BITS:0]   sum_total;
		res = '0;
		sts = STS_IGNORED;
		if (ev.command <= CMD_ABORT) begin
			from_mode = run_mode;
			case (from_mode)
				MODE_IDLE: begin
					case (ev.command)
						CMD_INC: begin
							add_step();
							run_mode = MODE_SET;
							sts = STS_TRANS;
						end
						CMD_START: begin
							run_mode = MODE_STAT;
							sts = STS_TRANS;
						end
						CMD_TICK: if (ev.tick_phase == cfg.beep_phase) sts = STS_HANDLED;
						default: ;
					endcase
				end
				MODE_SET: begin
					case (ev.command)
						CMD_INC: begin
							add_step();
							res.time_shown = 1'b1;
							res.shown_seconds = SHOW_W'(secs_left);
							sts = STS_HANDLED;
						end
						CMD_DEC: if (secs_left >= cfg.step_seconds) begin
							secs_left = secs_left - cfg.step_seconds;
							res.time_shown = 1'b1;
							res.shown_seconds = SHOW_W'(secs_left);
							sts = STS_HANDLED;
						end
						CMD_ABORT: begin
							run_mode = MODE_IDLE;
							sts = STS_TRANS;
						end
						CMD_START: if (secs_left >= cfg.step_seconds) begin
							run_mode = MODE_RUN;
							sts = STS_TRANS;
						end
						default: ;
					endcase
				end
				MODE_RUN: begin
					case (ev.command)
						CMD_TICK: if (ev.tick_phase == cfg.countdown_phase) begin
							if (secs_left != 0) secs_left = secs_left - 1'b1;
							if (secs_run != '1) secs_run = secs_run + 1'b1;
							res.time_shown = 1'b1;
							res.shown_seconds = SHOW_W'(secs_left);
							if (secs_left == 0) begin
								run_mode = MODE_IDLE;
								sts = STS_TRANS;
							end else begin
								sts = STS_HANDLED;
							end
						end
						CMD_START: begin
							run_mode = MODE_PAUSE;
							sts = STS_TRANS;
						end
						CMD_ABORT: begin
							run_mode = MODE_IDLE;
							sts = STS_TRANS;
						end
						default: ;
					endcase
				end
				MODE_PAUSE: begin
					case (ev.command)
						CMD_INC: begin
							add_step();
							run_mode = MODE_SET;
							sts = STS_TRANS;
						end
						CMD_DEC: if (secs_left >= cfg.step_seconds) begin
							secs_left = secs_left - cfg.step_seconds;
							run_mode = MODE_SET;
							sts = STS_TRANS;
						end
						CMD_START: begin
							run_mode = MODE_RUN;
							sts = STS_TRANS;
						end
						CMD_ABORT: begin
							run_mode = MODE_IDLE;
							sts = STS_TRANS;
						end
						default: ;
					endcase
				end
				MODE_STAT: begin
					if (ev.command == CMD_TICK) begin
						hold_seen = hold_seen + 1'b1;
						if (hold_seen == cfg.stat_hold_ticks) begin
							hold_seen = '0;
							run_mode = MODE_IDLE;
							sts = STS_TRANS;
						end
					end
				end
				default: ;
			endcase
			if (sts == STS_TRANS) begin
				// leave the old state, then enter the new one
				if (from_mode == MODE_RUN) begin
					sum_total = prod_total + secs_run;
					prod_total = sum_total[TOTAL_BITS] ? '1 : sum_total[TOTAL_BITS-1:0];
					secs_run = '0;
				end else begin
					res.display_cleared = 1'b1;
				end
				case (run_mode)
					MODE_IDLE: begin
						secs_left = '0;
						secs_run = '0;
						res.time_shown = 1'b1;
						res.shown_seconds = '0;
						res.message_code = MSG_SET;
					end
					MODE_SET: begin
						res.time_shown = 1'b1;
						res.shown_seconds = SHOW_W'(secs_left);
					end
					MODE_PAUSE: res.message_code = MSG_PAUSED;
					MODE_STAT: begin
						res.time_shown = 1'b1;
						res.shown_seconds = SHOW_W'(prod_total);
						res.message_code = MSG_PROD;
					end
					default: ;
				endcase
			end
		end
		res.status = sts;
		res.new_state = run_mode;
		res.remaining_seconds = REM_W'(secs_left);
		res.productive_total = PROD_W'(prod_total);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.step_seconds = STEP_RESET;
			cfg.countdown_phase = CD_PHASE_RESET;
			cfg.beep_phase = BEEP_RESET;
			cfg.stat_hold_ticks = HOLD_RESET;
			run_mode = MODE_IDLE;
			secs_left = '0;
			secs_run = '0;
			prod_total = '0;
			hold_seen = '0;
			timer_expect.delete();
			outstanding <= 0;
		end else begin
			if (result.valid && result.ready) begin
				got.status = result.status;
				got.new_state = result.new_state;
				got.display_cleared = result.display_cleared;
				got.time_shown = result.time_shown;
				got.shown_seconds = result.shown_seconds;
				got.message_code = result.message_code;
				got.remaining_seconds = result.remaining_seconds;
				got.productive_total = result.productive_total;
				if (timer_expect.size() == 0) begin
					report($sformatf("result beat with nothing pending, state %0d",
						got.new_state));
				end else begin
					want = timer_expect.pop_front();
					compare_field("status", 32'(got.status), 32'(want.status));
					compare_field("new_state", 32'(got.new_state), 32'(want.new_state));
					compare_field("display_cleared", 32'(got.display_cleared),
						32'(want.display_cleared));
					compare_field("time_shown", 32'(got.time_shown), 32'(want.time_shown));
					compare_field("shown_seconds", got.shown_seconds, want.shown_seconds);
					compare_field("message_code", 32'(got.message_code),
						32'(want.message_code));
					compare_field("remaining_seconds", 32'(got.remaining_seconds),
						32'(want.remaining_seconds));
					compare_field("productive_total", got.productive_total,
						want.productive_total);
				end
			end
			if (item.valid && item.ready) begin
				step_timer(item_t'({item.command, item.tick_phase}), want);
				timer_expect.push_back(want);
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_ADDR_W-1:2])
					REG_STEP:     cfg.step_seconds = pwdata[STEP_W-1:0];
					REG_CD_PHASE: cfg.countdown_phase = pwdata[PHASE_W-1:0];
					REG_BEEP:     cfg.beep_phase = pwdata[PHASE_W-1:0];
					REG_HOLD:     cfg.stat_hold_ticks = pwdata[HOLD_W-1:0];
					default: ;
				endcase
			end
			outstanding <= timer_expect.size();
		end
	end

endmodule

// File: tb/sv/tb_countdown_timer_controller_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Countdown timer controller testbench
// Drives button and tick event beats through several configuration phases
// with varying source gaps and sink stalls, and gives the verdict from the
// mismatch and outstanding counts of the result check beside the core.
// ----------------------------------------------------------------------------

module tb_countdown_timer_controller_core;
	import cdt_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int LONG_HOLD   = 200;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int unsigned mismatches;
	int unsigned outstanding;

	logic [STEP_W-1:0]  step_cfg = STEP_RESET;
	logic [PHASE_W-1:0] cd_cfg   = CD_PHASE_RESET;
	logic [HOLD_W-1:0]  hold_cfg = HOLD_RESET;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int events_sent    = 0;
	bit hold_off_go    = 1'b0;
	bit hold_off_done  = 1'b0;
	int hold_off_count = 0;

	cdt_item_if   item_ch();
	cdt_result_if result_ch();

	countdown_timer_controller_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_ch),
		.result  (result_ch)
	);

	cdt_timer_check u_timer_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.item        (item_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sink side: random stalls, plus one long hold-off on request
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_go && !hold_off_done) begin
				result_ch.ready <= 1'b0;
				hold_off_count = hold_off_count + 1;
				if (hold_off_count == LONG_HOLD) hold_off_done = 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet = quiet + 1;
		end
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [PHASE_W-1:0] phase);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.command <= cmd;
		item_ch.tick_phase <= phase;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		events_sent++;
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
		input logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [STEP_W-1:0] step, input logic [PHASE_W-1:0] cdp,
		input logic [PHASE_W-1:0] beep, input logic [HOLD_W-1:0] hold);
		drain();
		write_reg(REG_STEP, APB_DATA_W'(step));
		write_reg(REG_CD_PHASE, APB_DATA_W'(cdp));
		write_reg(REG_BEEP, APB_DATA_W'(beep));
		write_reg(REG_HOLD, APB_DATA_W'(hold));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		step_cfg = step;
		cd_cfg = cdp;
		hold_cfg = hold;
	endtask

	task automatic run_session();
		int pick;
		int k;
		int n;
		int r;
		pick = $urandom_range(99);
		if (pick < 45) begin
			// set a time, start, count down with the odd pause
			k = $urandom_range(1, 4);
			repeat (k) send_event(CMD_INC, PHASE_W'($urandom_range(15)));
			if ($urandom_range(3) == 0) send_event(CMD_DEC, PHASE_W'($urandom_range(15)));
			send_event(CMD_START, PHASE_W'($urandom_range(15)));
			n = step_cfg * k + 3;
			if (n > 300) n = 300;
			repeat (n) begin
				r = $urandom_range(99);
				if (r < 5)
					send_event(CMD_START, PHASE_W'($urandom_range(15)));
				else if (r < 88)
					send_event(CMD_TICK, cd_cfg);
				else
					send_event(CMD_TICK, PHASE_W'($urandom_range(15)));
			end
			if ($urandom_range(1)) send_event(CMD_ABORT, PHASE_W'($urandom_range(15)));
		end else if (pick < 62) begin
			// visit the statistics screen and tick it out
			send_event(CMD_ABORT, PHASE_W'($urandom_range(15)));
			send_event(CMD_START, PHASE_W'($urandom_range(15)));
			n = (hold_cfg == 0) ? 256 : int'(hold_cfg);
			repeat (n + 2) send_event(CMD_TICK, PHASE_W'($urandom_range(15)));
		end else if (pick < 72) begin
			// pile up increments on the remaining time, into saturation with a large step
			repeat (20) send_event(CMD_INC, PHASE_W'($urandom_range(15)));
			send_event(CMD_DEC, PHASE_W'($urandom_range(15)));
			send_event(CMD_ABORT, PHASE_W'($urandom_range(15)));
		end else if (pick < 84) begin
			// broken run: start, a few ticks, then drop or rework it
			send_event(CMD_INC, PHASE_W'($urandom_range(15)));
			send_event(CMD_START, PHASE_W'($urandom_range(15)));
			repeat ($urandom_range(1, 4)) send_event(CMD_TICK, cd_cfg);
			if ($urandom_range(1)) begin
				send_event(CMD_ABORT, PHASE_W'($urandom_range(15)));
			end else begin
				send_event(CMD_START, PHASE_W'($urandom_range(15)));
				send_event(CMD_DEC, PHASE_W'($urandom_range(15)));
				send_event(CMD_START, PHASE_W'($urandom_range(15)));
			end
		end else begin
			repeat (8) send_event(CMD_W'($urandom_range(7)), PHASE_W'($urandom_range(15)));
		end
	endtask

	task automatic run_until(input int goal);
		while (events_sent < goal) run_session();
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.command <= CMD_INC;
		item_ch.tick_phase <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_event(CMD_TICK, BEEP_RESET);
		send_event(CMD_TICK, '1);
		send_event(CMD_DEC, '0);
		send_event(CMD_ABORT, '0);
		for (int c = CMD_ABORT + 1; c < (1 << CMD_W); c++)
			send_event(CMD_W'(c), PHASE_W'(c));
		send_event(CMD_INC, '0);
		send_event(CMD_INC, '0);
		send_event(CMD_DEC, '0);
		send_event(CMD_DEC, '0);
		send_event(CMD_DEC, '0);
		send_event(CMD_START, '0);
		send_event(CMD_INC, '0);
		send_event(CMD_START, '0);
		send_event(CMD_DEC, '0);
		send_event(CMD_TICK, CD_PHASE_RESET);
		send_event(CMD_TICK, '0);
		send_event(CMD_START, '0);
		send_event(CMD_DEC, '0);
		send_event(CMD_INC, '0);
		send_event(CMD_INC, '0);
		send_event(CMD_START, '0);
		send_event(CMD_START, '0);
		send_event(CMD_DEC, '0);
		send_event(CMD_ABORT, '0);
		send_event(CMD_START, '0);
		send_event(CMD_INC, '0);
		run_until(320);

		apply_settings(STEP_W'(1), PHASE_W'(1), PHASE_W'(15), HOLD_W'(1));
		send_idle_pct = 61;
		recv_stall_pct = 0;
		run_until(640);

		apply_settings(STEP_W'(3600), PHASE_W'(15), PHASE_W'(1), HOLD_W'(255));
		send_idle_pct = 0;
		recv_stall_pct = 61;
		run_until(960);

		apply_settings('0, '0, '0, '0);
		send_idle_pct = 31;
		recv_stall_pct = 31;
		run_until(1250);

		apply_settings('1, PHASE_W'(7), PHASE_W'(9), HOLD_W'(2));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_go <= 1'b1;
		run_until(1400);
		drain();
		run_until(1550);

		apply_settings(STEP_W'(2), PHASE_W'(10), PHASE_W'(5), HOLD_W'(5));
		while (events_sent < 1850) begin
			send_idle_pct = ($urandom_range(2) == 0) ? 0 : 61;
			recv_stall_pct = ($urandom_range(2) == 0) ? 0 : 61;
			run_session();
		end

		drain();
		repeat (6) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/cdt_pkg.sv
hw/rtl/cdt_if.sv
hw/rtl/cdt_cfg_regs.sv
hw/rtl/cdt_fsm.sv
hw/rtl/countdown_timer_controller_core.sv
tb/sv/cdt_timer_check.sv
tb/sv/tb_countdown_timer_controller_core.sv
